// ===== sv/tsp_pkg.sv =====
// tsp_pkg: shared types and constants of the transport stream packetizer.
// Used by the channel interfaces, controller, datapath, divider and checker.
// No dependencies.
package tsp_pkg;

   // Packet geometry
   localparam int unsigned PKT_BYTES_N = 188;
   localparam int unsigned WORDS_PER_PKT = 47;
   localparam logic [7:0] PKT_BYTES = 8'd188;
   localparam logic [7:0] LAST_BYTE_POS = 8'd187;
   localparam logic [7:0] CAP_PLAIN = 8'd184;
   localparam logic [7:0] CAP_PCR = 8'd176;
   localparam int unsigned STORE_DEPTH = 184;
   localparam int unsigned STORE_AW = $clog2(STORE_DEPTH);

   // Header and adaptation field codes
   localparam logic [7:0] SYNC_BYTE = 8'h47;
   localparam logic [7:0] STUFF_BYTE = 8'hFF;
   localparam logic [7:0] AF_FLAGS_PCR = 8'h10;
   localparam logic [7:0] AF_FLAGS_NONE = 8'h00;
   localparam logic [3:0] AFC_PAYLOAD = 4'h1;
   localparam logic [3:0] AFC_BOTH = 4'h3;
   localparam logic [5:0] PCR_RESERVED = 6'h3F;

   // Configuration
   localparam int unsigned PID_W = 13;
   localparam logic [PID_W-1:0] PID_RESET = 13'd256;

   // PCR split: base = pcr / 300, extension = pcr % 300, seven dividend bits per step
   localparam int unsigned PCR_W = 42;
   localparam int unsigned PCR_BASE_W = 33;
   localparam int unsigned PCR_EXT_W = 9;
   localparam logic [PCR_EXT_W:0] PCR_DIVISOR = 10'd300;
   localparam int unsigned DIV_DIGIT_W = 7;
   localparam int unsigned DIV_STEPS = PCR_W / DIV_DIGIT_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

   // Partial remainder with the next digit appended, and its reciprocal product
   localparam int unsigned DIV_T_W = PCR_EXT_W + DIV_DIGIT_W;
   localparam int unsigned DIV_SHIFT = DIV_T_W + PCR_EXT_W;
   localparam int unsigned DIV_P_W = DIV_SHIFT + DIV_DIGIT_W;
   localparam int unsigned DIV_RECIP_W = 17;
   localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 17'd111849;   // ceil(2^25 / 300)

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_STREAM
   } tsp_state_type;

   // Controller to datapath
   typedef struct packed {
      logic take;       // accept the input transaction this cycle
      logic div_start;  // launch the PCR split
      logic stream_en;  // packet bytes may move toward the output
   } tsp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic emit;       // current input closes a packet
      logic pcr_pkt;    // that packet carries a PCR
      logic div_done;   // PCR split finished
      logic pkt_done;   // last word of the packet loaded into the output
   } tsp_status_type;

endpackage

// ===== sv/tsp_channels.sv =====
// tsp_channels: valid/ready channel interfaces of the packetizer.
// Depends on tsp_pkg for field widths.
interface tsp_req_if;
   logic                         valid;
   logic                         ready;
   logic [7:0]                   data_byte;
   logic                         unit_start;
   logic                         with_pcr;
   logic [tsp_pkg::PCR_W-1:0]    pcr_value;
   logic                         last_byte;

   modport source (output valid, data_byte, unit_start, with_pcr, pcr_value, last_byte,
                   input ready);
   modport sink (input valid, data_byte, unit_start, with_pcr, pcr_value, last_byte,
                 output ready);
endinterface

interface tsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] ts_word;
   logic        packet_end;

   modport source (output valid, ts_word, packet_end, input ready);
   modport sink (input valid, ts_word, packet_end, output ready);
endinterface

// ===== sv/tsp_div.sv =====
// tsp_div: splits a 42-bit PCR into quotient and remainder by 300,
// seven dividend bits per cycle, each digit by reciprocal multiplication. Depends on tsp_pkg.
module tsp_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [tsp_pkg::PCR_W-1:0]         dividend,
   output logic                              done,
   output logic [tsp_pkg::PCR_BASE_W-1:0]    base,
   output logic [tsp_pkg::PCR_EXT_W-1:0]     ext
);

   logic [tsp_pkg::PCR_W-1:0]        q_ff, q_in;
   logic [tsp_pkg::PCR_EXT_W-1:0]    r_ff, r_in;
   logic [tsp_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [tsp_pkg::DIV_T_W-1:0]      trial;
   logic [tsp_pkg::DIV_P_W-1:0]      prod;
   logic [tsp_pkg::DIV_DIGIT_W-1:0]  digit;
   logic [tsp_pkg::DIV_T_W-1:0]      back;

   // One step: append the next seven dividend bits, quotient digit from the reciprocal
   always_comb begin
      trial = {r_ff, q_ff[tsp_pkg::PCR_W-1 -: tsp_pkg::DIV_DIGIT_W]};
      prod = tsp_pkg::DIV_P_W'(trial) * tsp_pkg::DIV_P_W'(tsp_pkg::DIV_RECIP);
      digit = prod[tsp_pkg::DIV_P_W-1 -: tsp_pkg::DIV_DIGIT_W];
      back = tsp_pkg::DIV_T_W'(digit) * tsp_pkg::DIV_T_W'(tsp_pkg::PCR_DIVISOR);
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in = dividend;
         r_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in = {q_ff[tsp_pkg::PCR_W-tsp_pkg::DIV_DIGIT_W-1:0], digit};
         r_in = tsp_pkg::PCR_EXT_W'(trial - back);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == tsp_pkg::DIV_LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   // Quotient and remainder
   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign done = done_ff;
   assign base = q_ff[tsp_pkg::PCR_BASE_W-1:0];   // modulo 2^33
   assign ext = r_ff;

endmodule

// ===== sv/tsp_ctrl.sv =====
// tsp_ctrl: packetizer controller. Takes bytes while idle, runs the PCR split
// and the packet stream-out. Depends on tsp_pkg.
module tsp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tsp_pkg::tsp_status_type stat,
   output tsp_pkg::tsp_cmd_type    cmd
);

   tsp_pkg::tsp_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         tsp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take = req_valid;
            if (req_valid && stat.emit) begin
               cmd.div_start = stat.pcr_pkt;
               state_in = stat.pcr_pkt ? tsp_pkg::ST_DIV : tsp_pkg::ST_STREAM;
            end
         end
         tsp_pkg::ST_DIV: begin
            if (stat.div_done) begin
               state_in = tsp_pkg::ST_STREAM;
            end
         end
         tsp_pkg::ST_STREAM: begin
            cmd.stream_en = 1'b1;
            if (stat.pkt_done) begin
               state_in = tsp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tsp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/tsp_dp.sv =====
// tsp_dp: packetizer datapath: payload store, unit state, header generator,
// word assembler and output register. Depends on tsp_pkg and tsp_div.
module tsp_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  tsp_pkg::tsp_cmd_type         cmd,
   output tsp_pkg::tsp_status_type      stat,
   input  logic [7:0]                   in_data_byte,
   input  logic                         in_unit_start,
   input  logic                         in_with_pcr,
   input  logic [tsp_pkg::PCR_W-1:0]    in_pcr_value,
   input  logic                         in_last_byte,
   input  logic                         csr_we,
   input  logic [tsp_pkg::PID_W-1:0]    csr_wdata,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [31:0]                  out_ts_word,
   output logic                         out_packet_end
);

   // Unit state
   logic [tsp_pkg::PID_W-1:0]  pid_ff;
   logic [7:0]                 fill_ff;
   logic [3:0]                 cc_ff;
   logic                       first_ff;
   logic                       pcrw_ff;
   logic [tsp_pkg::PCR_W-1:0]  pcr_ff;

   // Packet being sent
   logic [7:0]                 pn_ff;
   logic                       ppcr_ff;
   logic                       pstart_ff;
   logic [3:0]                 pcc_ff;

   // Stream-out pipeline
   logic [7:0]                 k_ff;
   logic                       s1_v_ff;
   logic                       s1_pay_ff;
   logic                       s1_last_ff;
   logic [7:0]                 s1_const_ff;
   logic [7:0]                 rdata_ff;
   logic [23:0]                asm_ff;
   logic [1:0]                 bcnt_ff;
   logic                       out_v_ff;
   logic [31:0]                out_word_ff;
   logic                       out_end_ff;

   logic [7:0] store_ff [tsp_pkg::STORE_DEPTH];

   // Input step
   logic [7:0]                 fill_base;
   logic [7:0]                 fill_new;
   logic                       first_c;
   logic                       pcrw_c;
   logic                       pcr_pkt_c;
   logic [7:0]                 cap_c;
   logic                       emit_c;
   logic                       pkt_take;
   logic [tsp_pkg::PCR_W-1:0]  div_src;

   // Byte generation
   logic [7:0]                 pay_off;
   logic                       s0_v;
   logic                       s0_pay;
   logic [7:0]                 rd_off;
   logic [7:0]                 const_byte;
   logic                       full_plain;
   logic                       out_free;
   logic                       word_ready;
   logic                       adv;
   logic [7:0]                 s1_byte;
   logic                       div_done;
   logic [tsp_pkg::PCR_BASE_W-1:0] base;
   logic [tsp_pkg::PCR_EXT_W-1:0]  ext;

   // Effect of the offered byte on the unit state
   always_comb begin
      fill_base = in_unit_start ? 8'd0 : fill_ff;
      fill_new = fill_base + 8'd1;
      first_c = in_unit_start | first_ff;
      pcrw_c = in_unit_start ? in_with_pcr : pcrw_ff;
      pcr_pkt_c = first_c & pcrw_c;
      cap_c = pcr_pkt_c ? tsp_pkg::CAP_PCR : tsp_pkg::CAP_PLAIN;
      emit_c = (fill_new >= cap_c) | in_last_byte;
      div_src = in_unit_start ? in_pcr_value : pcr_ff;
   end

   assign pkt_take = cmd.take & emit_c;

   tsp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_src),
      .done     (div_done),
      .base     (base),
      .ext      (ext)
   );

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         pid_ff <= tsp_pkg::PID_RESET;
      end else if (csr_we) begin
         pid_ff <= csr_wdata;
      end
   end

   // Unit state update on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         cc_ff <= '0;
         first_ff <= 1'b0;
         pcrw_ff <= 1'b0;
         pcr_ff <= '0;
      end else if (cmd.take) begin
         if (in_unit_start) begin
            pcr_ff <= in_pcr_value;
         end
         if (emit_c) begin
            fill_ff <= '0;
            first_ff <= 1'b0;
            pcrw_ff <= in_last_byte ? 1'b0 : pcrw_c;
            cc_ff <= cc_ff + 4'd1;
         end else begin
            fill_ff <= fill_new;
            first_ff <= first_c;
            pcrw_ff <= pcrw_c;
         end
      end
   end

   // Snapshot of the packet to send
   always_ff @(posedge clock) begin
      if (pkt_take) begin
         pn_ff <= fill_new;
         ppcr_ff <= pcr_pkt_c;
         pstart_ff <= first_c;
         pcc_ff <= cc_ff;
      end
   end

   // Payload store write
   always_ff @(posedge clock) begin
      if (cmd.take && (fill_base < tsp_pkg::CAP_PLAIN)) begin
         store_ff[fill_base[tsp_pkg::STORE_AW-1:0]] <= in_data_byte;
      end
   end

   // Byte k of the packet: payload sits at the tail, header and stuffing before it
   always_comb begin
      pay_off = tsp_pkg::PKT_BYTES - pn_ff;
      s0_v = cmd.stream_en && (k_ff < tsp_pkg::PKT_BYTES);
      s0_pay = (k_ff >= pay_off);
      rd_off = k_ff - pay_off;
      full_plain = !ppcr_ff && (pn_ff == tsp_pkg::CAP_PLAIN);
      case (k_ff)
         8'd0:    const_byte = tsp_pkg::SYNC_BYTE;
         8'd1:    const_byte = {1'b0, pstart_ff, 1'b0, pid_ff[12:8]};
         8'd2:    const_byte = pid_ff[7:0];
         8'd3:    const_byte = {full_plain ? tsp_pkg::AFC_PAYLOAD : tsp_pkg::AFC_BOTH,
                                pcc_ff};
         8'd4:    const_byte = (tsp_pkg::CAP_PLAIN - 8'd1) - pn_ff;
         8'd5:    const_byte = ppcr_ff ? tsp_pkg::AF_FLAGS_PCR : tsp_pkg::AF_FLAGS_NONE;
         8'd6:    const_byte = ppcr_ff ? base[32:25] : tsp_pkg::STUFF_BYTE;
         8'd7:    const_byte = ppcr_ff ? base[24:17] : tsp_pkg::STUFF_BYTE;
         8'd8:    const_byte = ppcr_ff ? base[16:9] : tsp_pkg::STUFF_BYTE;
         8'd9:    const_byte = ppcr_ff ? base[8:1] : tsp_pkg::STUFF_BYTE;
         8'd10:   const_byte = ppcr_ff ? {base[0], tsp_pkg::PCR_RESERVED, ext[8]}
                                       : tsp_pkg::STUFF_BYTE;
         8'd11:   const_byte = ppcr_ff ? ext[7:0] : tsp_pkg::STUFF_BYTE;
         default: const_byte = tsp_pkg::STUFF_BYTE;
      endcase
   end

   // Pipeline moves unless a finished word has nowhere to go
   assign out_free = !out_v_ff || out_ready;
   assign word_ready = s1_v_ff && (bcnt_ff == 2'd3);
   assign adv = cmd.stream_en && (!word_ready || out_free);
   assign s1_byte = s1_pay_ff ? rdata_ff : s1_const_ff;

   // Payload store read
   always_ff @(posedge clock) begin
      if (adv && s0_v && s0_pay) begin
         rdata_ff <= store_ff[rd_off[tsp_pkg::STORE_AW-1:0]];
      end
   end

   // Byte counter and stage-one valid
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
         s1_v_ff <= 1'b0;
         bcnt_ff <= '0;
      end else if (pkt_take) begin
         k_ff <= '0;
         s1_v_ff <= 1'b0;
         bcnt_ff <= '0;
      end else if (adv) begin
         s1_v_ff <= s0_v;
         if (s0_v) begin
            k_ff <= k_ff + 8'd1;
         end
         if (s1_v_ff) begin
            bcnt_ff <= bcnt_ff + 2'd1;
         end
      end
   end

   // Stage-one payload and word assembly
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pay_ff <= s0_pay;
         s1_const_ff <= const_byte;
         s1_last_ff <= (k_ff == tsp_pkg::LAST_BYTE_POS);
         if (s1_v_ff) begin
            asm_ff <= {asm_ff[15:0], s1_byte};
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv && word_ready) begin
         out_v_ff <= 1'b1;
      end else if (out_ready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && word_ready) begin
         out_word_ff <= {asm_ff, s1_byte};
         out_end_ff <= s1_last_ff;
      end
   end

   assign out_valid = out_v_ff;
   assign out_ts_word = out_word_ff;
   assign out_packet_end = out_end_ff;

   // Status to the controller
   always_comb begin
      stat.emit = emit_c;
      stat.pcr_pkt = pcr_pkt_c;
      stat.div_done = div_done;
      stat.pkt_done = adv && word_ready && s1_last_ff;
   end

endmodule

// ===== sv/ts_packetizer.sv =====
// ts_packetizer: packs payload units into 188-byte transport packets, 47 words each.
// Takes one payload byte per cycle while a packet fills; the closing byte drops input
// ready for the byte-serial stream-out from the payload store (one read port),
// preceded by the PCR split for a first packet with PCR, and for any output stalls.
// Reset (synchronous): PID 256, continuity counter 0, no unit open, output empty.
module ts_packetizer (
   input  logic                           clock,
   input  logic                           reset,
   tsp_req_if.sink                        req_chan,
   tsp_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [tsp_pkg::PID_W-1:0]      csr_wdata
);

   tsp_pkg::tsp_cmd_type    cmd;
   tsp_pkg::tsp_status_type stat;
   logic                    req_ready;

   // Controller
   tsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   // Datapath
   tsp_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .in_data_byte   (req_chan.data_byte),
      .in_unit_start  (req_chan.unit_start),
      .in_with_pcr    (req_chan.with_pcr),
      .in_pcr_value   (req_chan.pcr_value),
      .in_last_byte   (req_chan.last_byte),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .out_valid      (rsp_chan.valid),
      .out_ready      (rsp_chan.ready),
      .out_ts_word    (rsp_chan.ts_word),
      .out_packet_end (rsp_chan.packet_end)
   );

endmodule

// ===== sv/tsp_checker.sv =====
// tsp_checker: port-level assertions for ts_packetizer, attached by bind.
// Depends on tsp_pkg and the top level's ports.
module tsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_packet_end
);

   localparam int unsigned WCNT_W = $clog2(tsp_pkg::WORDS_PER_PKT);
   localparam logic [WCNT_W-1:0] WCNT_LAST = WCNT_W'(tsp_pkg::WORDS_PER_PKT - 1);

   logic [WCNT_W-1:0] wcnt_ff;

   // Word position within the current packet
   always_ff @(posedge clock) begin
      if (reset) begin
         wcnt_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         wcnt_ff <= (wcnt_ff == WCNT_LAST) ? '0 : wcnt_ff + 1'b1;
      end
   end

   // Result transaction stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // Output is empty right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // Every packet is exactly 47 words, end flag on the last one only
   a_pkt_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> (rsp_packet_end == (wcnt_ff == WCNT_LAST)))
      else $error("packet_end out of place");

   // The final byte of a unit always closes a packet, so input is held off next
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_byte |=> !req_ready)
      else $error("input still open after last byte");

endmodule

bind ts_packetizer tsp_checker u_tsp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_last_byte  (req_chan.last_byte),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_packet_end (rsp_chan.packet_end)
);
